>>> rtl/core/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

  // Number of fraction bits of the Q formats.
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 17;
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int STEP_W  = $clog2(FRAC_BITS + 1);
  localparam int MCAND_W = DATA_W + 2;
  localparam int PROD_W  = DATA_W + 3;

  // Register reset values.
  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = 32'd9830;
  localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = 32'd655;
  localparam logic [DATA_W-1:0] INITIAL_ESTIMATE_RST  = 32'd655360;
  localparam logic [DATA_W-1:0] INITIAL_VARIANCE_RST  = 32'd655369830;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PROCESS_NOISE     = 2'd0,
    CFG_MEASUREMENT_NOISE = 2'd1,
    CFG_INITIAL_ESTIMATE  = 2'd2,
    CFG_INITIAL_VARIANCE  = 2'd3
  } cfg_index_t;

  // Commands of an input transaction.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  // Control strobes from the sequencer to the datapath.
  typedef struct packed {
    logic accept;
    logic div_start;
    logic mul_start;
    logic finish;
    logic load_out;
  } ctrl_t;

endpackage

>>> rtl/core/scalar_kalman_filter_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// input     in_valid/in_stall   cmd, measurement
// output    out_valid/out_stall estimate, gain, variance
// config    cfg_we              cfg_index, cfg_data (no stall, no read-back)
//
// A filter transaction passes from acceptance to the result register through
// the serial divider, the start of the multipliers, the two serial
// multipliers working side by side, the update of the filter state and the
// holding stage, and the load of the result register. The next input is taken
// only after that, so one transaction is through before the next starts. A
// reinit transaction loads the filter state and the holding stage at acceptance
// and then reaches the result register; the next input is taken after that.
// Reset is synchronous and restores the registers and the filter state.
// A stalled output holds; the next input is taken while a result waits, and
// the finished result of that transaction waits in a holding stage.

module scalar_kalman_filter_unit
  import skf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     cmd,
  input  logic signed [DATA_W-1:0] measurement,
  // Output channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] estimate,
  output logic [GAIN_W-1:0]        gain,
  output logic [DATA_W-1:0]        variance,
  // Configuration port.
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  // Configuration registers.
  logic [DATA_W-1:0] process_noise;
  logic [DATA_W-1:0] measurement_noise;
  logic [DATA_W-1:0] initial_estimate;
  logic [DATA_W-1:0] initial_variance;

  // Filter state.
  logic signed [DATA_W-1:0] cur_est;
  logic [DATA_W-1:0]        pred_var;

  // Working registers of one transaction.
  logic signed [DATA_W-1:0] z;
  logic                     den_zero;
  logic [QUO_W-1:0]         gain_q;

  // Holding stage for a finished result.
  logic signed [DATA_W-1:0] hold_est;
  logic [GAIN_W-1:0]        hold_gain;
  logic [DATA_W-1:0]        hold_var;

  state_t state;
  state_t state_next;
  ctrl_t  ctrl;

  // Serial unit wiring.
  logic [DATA_W:0]           den;
  logic                      div_done;
  logic [QUO_W-1:0]          quotient;
  logic [QUO_W-1:0]          gain_use;
  logic [QUO_W-1:0]          one_minus;
  logic signed [DATA_W:0]    diff;
  logic                      m0_done;
  logic                      m1_done;
  logic signed [PROD_W-1:0]  prod0;
  logic signed [PROD_W-1:0]  prod1;
  logic                      mul_done;

  // Update arithmetic after the multipliers.
  logic signed [PROD_W:0]    est_sum;
  logic signed [DATA_W-1:0]  est_new;
  logic [DATA_W-1:0]         post;
  logic [DATA_W:0]           next_sum;
  logic [DATA_W-1:0]         pv_new;

  assign mul_done = m0_done & m1_done;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_REINIT) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl      = '0;
    in_stall  = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall       = 1'b0;
        ctrl.accept    = in_valid;
        ctrl.div_start = in_valid && (cmd == CMD_FILTER);
      end
      ST_DIV: begin
        ctrl.mul_start = div_done;
      end
      ST_MUL: begin
        ctrl.finish = mul_done;
      end
      ST_DONE: begin
        ctrl.load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; an index outside the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PROCESS_NOISE_RST;
      measurement_noise <= MEASUREMENT_NOISE_RST;
      initial_estimate  <= INITIAL_ESTIMATE_RST;
      initial_variance  <= INITIAL_VARIANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROCESS_NOISE:     process_noise     <= cfg_data;
        CFG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
        CFG_INITIAL_ESTIMATE:  initial_estimate  <= cfg_data;
        CFG_INITIAL_VARIANCE:  initial_variance  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The divisor pv + r is captured by the divider when it starts.
  assign den = {1'b0, pred_var} + {1'b0, measurement_noise};

  skf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (pred_var),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // A zero divisor means pv is zero as well, and the gain is forced to zero.
  assign gain_use  = den_zero ? '0 : quotient;
  assign one_minus = QUO_W'(1 << FRAC_BITS) - gain_use;
  assign diff      = $signed({z[DATA_W-1], z}) -
                     $signed({cur_est[DATA_W-1], cur_est});

  // Innovation times gain, shifted down with rounding toward minus infinity.
  skf_mul u_mul_est (
    .clk     (clk),
    .rst     (rst),
    .start   (ctrl.mul_start),
    .mcand   (MCAND_W'(diff)),
    .mplier  (gain_use),
    .done    (m0_done),
    .product (prod0)
  );

  // Predicted variance times one minus gain.
  skf_mul u_mul_var (
    .clk     (clk),
    .rst     (rst),
    .start   (ctrl.mul_start),
    .mcand   ($signed({2'b00, pred_var})),
    .mplier  (one_minus),
    .done    (m1_done),
    .product (prod1)
  );

  // New estimate, clamped to the signed 32 bit range; the update lies between
  // the old estimate and the measurement, so the clamp never bites in practice.
  always_comb begin
    est_sum = (PROD_W + 1)'(cur_est) + (PROD_W + 1)'(prod0);
    if (est_sum > (PROD_W + 1)'(32'sh7fffffff)) begin
      est_new = 32'sh7fffffff;
    end else if (est_sum < -(PROD_W + 1)'(33'sh080000000)) begin
      est_new = 32'sh80000000;
    end else begin
      est_new = est_sum[DATA_W-1:0];
    end
    post     = prod1[DATA_W-1:0];
    next_sum = {1'b0, post} + {1'b0, process_noise};
    pv_new   = next_sum[DATA_W] ? '1 : next_sum[DATA_W-1:0];
  end

  // Filter state and transaction registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_est  <= INITIAL_ESTIMATE_RST;
      pred_var <= INITIAL_VARIANCE_RST;
    end else if (ctrl.accept && (cmd == CMD_REINIT)) begin
      cur_est  <= initial_estimate;
      pred_var <= initial_variance;
    end else if (ctrl.finish) begin
      cur_est  <= est_new;
      pred_var <= pv_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_start) begin
      z        <= measurement;
      den_zero <= (den == '0);
    end
    if (ctrl.mul_start) begin
      gain_q <= gain_use;
    end
    if (ctrl.accept && (cmd == CMD_REINIT)) begin
      hold_est  <= initial_estimate;
      hold_gain <= '0;
      hold_var  <= initial_variance;
    end else if (ctrl.finish) begin
      hold_est  <= est_new;
      hold_gain <= GAIN_W'(gain_q);
      hold_var  <= post;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      estimate <= hold_est;
      gain     <= hold_gain;
      variance <= hold_var;
    end
  end

endmodule

>>> rtl/core/skf_div.sv
`timescale 1ns / 1ps

// Restoring divider that yields one quotient bit per cycle, most significant bit
// first, with FRAC_BITS fraction bits. The dividend must not exceed the divisor,
// so the quotient fits in FRAC_BITS + 1 bits.
module skf_div
  import skf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DATA_W-1:0]   dividend,
  input  logic [DATA_W:0]     divisor,
  output logic                done,
  output logic [QUO_W-1:0]    quotient
);

  logic [DATA_W+1:0] rem;
  logic [DATA_W+1:0] rem_next;
  logic [DATA_W:0]   dvs;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              ge;
  logic [DATA_W+1:0] rem_sub;
  logic [DATA_W+1:0] rem_keep;

  always_comb begin
    ge       = (rem >= {1'b0, dvs});
    rem_sub  = rem - {1'b0, dvs};
    rem_keep = ge ? rem_sub : rem;
    rem_next = {rem_keep[DATA_W:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {2'b00, dividend};
      dvs <= divisor;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[QUO_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/skf_mul.sv
`timescale 1ns / 1ps

// Serial shift-add multiplier, multiplier bits taken least significant first.
// Each of the first FRAC_BITS steps adds and shifts right by one, dropping
// the fraction; the last step adds without a shift. The result is
// floor(mcand * mplier / 2^FRAC_BITS), signed.
module skf_mul
  import skf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [MCAND_W-1:0]  mcand,
  input  logic [QUO_W-1:0]           mplier,
  output logic                       done,
  output logic signed [PROD_W-1:0]   product
);

  logic signed [MCAND_W-1:0] m;
  logic [QUO_W-1:0]          bits;
  logic [STEP_W-1:0]         cnt;
  logic                      busy;
  logic signed [PROD_W-1:0]  sum;

  assign sum = product + (bits[0] ? PROD_W'(m) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m       <= mcand;
      bits    <= mplier;
      product <= '0;
    end else if (busy) begin
      bits <= bits >> 1;
      if (cnt == STEP_W'(FRAC_BITS)) begin
        product <= sum;
      end else begin
        product <= sum >>> 1;
      end
    end
  end

endmodule
